### design/dkmt_pkg.sv
`default_nettype none

package dkmt_pkg;

    localparam int KEY_W     = 56;
    localparam int HANDLER_W = 4;
    localparam int TAG_W     = 16;
    localparam int SEQ_W     = 32;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int INDEX_W   = 4;

    localparam logic [ACTION_W-1:0] ACT_ARM    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DISARM = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [KEY_W-1:0]     key;
        logic [HANDLER_W-1:0] handler_id;
        logic [TAG_W-1:0]     feed_tag;
        logic [SEQ_W-1:0]     seq_number;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 hit;
        logic [INDEX_W-1:0]   entry_index;
        logic [HANDLER_W-1:0] match_handler;
        logic [TAG_W-1:0]     match_tag;
        logic [SEQ_W-1:0]     match_seq;
    } rsp_t;

    // everything an entry holds apart from its key
    typedef struct packed {
        logic [HANDLER_W-1:0] handler;
        logic [TAG_W-1:0]     tag;
        logic [SEQ_W-1:0]     seq;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic write;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_SEL,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

### design/dkmt_stream_if.sv
`default_nettype none

interface dkmt_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/dkmt_cell.sv
`default_nettype none

module dkmt_cell
    import dkmt_pkg::*;
#(
    parameter int KEY_BITS = 56
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic                valid,
    input  wire logic [KEY_BITS-1:0] probe_key,
    input  wire logic [KEY_BITS-1:0] wr_key,
    input  wire entry_t              wr_entry,
    input  wire logic [KEY_BITS-1:0] nb_key,
    input  wire entry_t              nb_entry,
    input  wire logic                below_in,
    output logic                     below_out,
    output logic                     first,
    output logic [KEY_BITS-1:0]      key,
    output entry_t                   entry
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    entry_t              entry_reg;
    entry_t              entry_next;
    logic                match_reg;
    logic                match_next;

    always_comb
    begin
        key_next   = key_reg;
        entry_next = entry_reg;
        if (ctrl.write)
        begin
            key_next   = wr_key;
            entry_next = wr_entry;
        end
        else if (ctrl.shift)
        begin
            key_next   = nb_key;
            entry_next = nb_entry;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = valid && (probe_key == key_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    // lowest match wins: a match below this cell masks it
    assign below_out = below_in | match_reg;
    assign first     = match_reg & ~below_in;
    assign key       = key_reg;
    assign entry     = entry_reg;

endmodule

`default_nettype wire

### design/demux_key_match_table.sv
// A request word passes the compare, select and execute steps over the row
// of entry cells; a new request is taken only after the last one has left
// execute, and execute waits while an earlier result is still unread.
// A request is taken while an earlier result still waits at the output.
// Reset (rst_n, async, active low) empties the table; entry contents are
// left as they are and only entries below the count are ever used.
`default_nettype none

module demux_key_match_table
    import dkmt_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 56
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    dkmt_stream_if.sink   req,
    dkmt_stream_if.source rsp
);

    localparam int SK    = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IXW   = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t               state_reg;
    state_t               state_next;
    req_t                 req_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 found_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_sel;
    entry_t               sel_entry_reg;
    entry_t               ent_sel;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;

    logic                 capture;
    logic                 sel_load;
    logic                 exec_go;
    logic                 do_write;
    logic                 do_shift;
    logic [IDX_W-1:0]     wr_idx;
    logic [IXW-1:0]       ix_hit;
    logic [IXW-1:0]       ix_new;

    logic [DEPTH:0]       below;
    logic [DEPTH-1:0]     first;
    logic [DEPTH-1:0]     valid;
    cell_ctrl_t           ctrl   [DEPTH];
    logic [SK-1:0]        cell_key   [DEPTH];
    entry_t               cell_entry [DEPTH];
    entry_t               wr_entry;

    assign below[0] = 1'b0;
    assign wr_entry = '{handler: req_reg.handler_id, tag: req_reg.feed_tag,
                        seq: req_reg.seq_number};

    // ---------------------------------------------------------------- cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [SK-1:0] nb_key;
        entry_t        nb_entry;

        if (i == DEPTH - 1)
        begin : g_last
            assign nb_key   = cell_key[i];
            assign nb_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign nb_key   = cell_key[i+1];
            assign nb_entry = cell_entry[i+1];
        end

        assign valid[i]         = CNT_W'(i) < count_reg;
        assign ctrl[i].capture  = capture;
        assign ctrl[i].write    = exec_go && do_write && (wr_idx == IDX_W'(i));
        assign ctrl[i].shift    = exec_go && do_shift && (IDX_W'(i) >= idx_reg)
                                  && (CNT_W'(i + 1) < count_reg);

        dkmt_cell #(
            .KEY_BITS (SK)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[i]),
            .valid     (valid[i]),
            .probe_key (req_reg.key[SK-1:0]),
            .wr_key    (req_reg.key[SK-1:0]),
            .wr_entry  (wr_entry),
            .nb_key    (nb_key),
            .nb_entry  (nb_entry),
            .below_in  (below[i]),
            .below_out (below[i+1]),
            .first     (first[i]),
            .key       (cell_key[i]),
            .entry     (cell_entry[i])
        );
    end

    // ------------------------------------------------------------ control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:  state_next = ST_SEL;
            ST_SEL:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        capture   = 1'b0;
        sel_load  = 1'b0;
        exec_go   = 1'b0;
        case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_CMP:  capture   = 1'b1;
            ST_SEL:  sel_load  = 1'b1;
            ST_EXEC: exec_go   = !rsp_valid_reg || rsp.ready;
            default: req.ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------- select
    always_comb
    begin
        idx_sel = '0;
        ent_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                idx_sel = idx_sel | IDX_W'(i);
                ent_sel = entry_t'(ent_sel | cell_entry[i]);
            end
        end
    end

    // ------------------------------------------------------------ execute
    always_comb
    begin
        rsp_next   = '0;
        do_write   = 1'b0;
        do_shift   = 1'b0;
        wr_idx     = idx_reg;
        count_next = count_reg;
        ix_hit     = IXW'(idx_reg);
        ix_new     = IXW'(count_reg);
        case (req_reg.action)
            ACT_ARM:
            begin
                if (found_reg)
                begin
                    do_write             = 1'b1;
                    rsp_next.entry_index = ix_hit[INDEX_W-1:0];
                end
                else if (count_reg == FULL_COUNT)
                begin
                    rsp_next.status = STS_FULL;
                end
                else
                begin
                    do_write             = 1'b1;
                    wr_idx               = count_reg[IDX_W-1:0];
                    count_next           = count_reg + 1'b1;
                    rsp_next.entry_index = ix_new[INDEX_W-1:0];
                end
            end
            ACT_DISARM:
            begin
                if (found_reg)
                begin
                    do_shift             = 1'b1;
                    count_next           = count_reg - 1'b1;
                    rsp_next.entry_index = ix_hit[INDEX_W-1:0];
                end
                else
                begin
                    rsp_next.status = STS_MISS;
                end
            end
            ACT_LOOKUP:
            begin
                if (found_reg)
                begin
                    rsp_next.hit           = 1'b1;
                    rsp_next.entry_index   = ix_hit[INDEX_W-1:0];
                    rsp_next.match_handler = sel_entry_reg.handler;
                    rsp_next.match_tag     = sel_entry_reg.tag;
                    rsp_next.match_seq     = sel_entry_reg.seq;
                end
                else
                begin
                    rsp_next.status = STS_MISS;
                end
            end
            default: rsp_next = '0;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg <= req.data;
        end
        if (sel_load)
        begin
            found_reg     <= below[DEPTH];
            idx_reg       <= idx_sel;
            sel_entry_reg <= ent_sel;
        end
        if (exec_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above table depth");

    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first))
        else $error("more than one first match");

    a_disarm_count: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && req_reg.action == ACT_DISARM && found_reg)
        |=> count_reg == CNT_W'($past(count_reg) - 1'b1))
        else $error("disarm did not shrink the table");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && req_reg.action == ACT_ARM && !found_reg && count_reg == FULL_COUNT)
        |=> (rsp_reg.status == STS_FULL && count_reg == FULL_COUNT))
        else $error("arm on full table not reported");
`endif

endmodule

`default_nettype wire
